>>> sv/assert_macros.svh
// Assertion macros used by the top level of the decimal text converter.
// Has no dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/ftda_pkg.sv
// Package of the fixed-point to decimal text converter: types and constants.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ftda_pkg;

    localparam int VALUE_WIDTH  = 48;
    localparam int CHAR_WIDTH   = 8;
    localparam int PLACES_WIDTH = 3;
    localparam int INT_DIGITS   = 10;
    localparam int DCNT_WIDTH   = 4;
    localparam int LIMIT_WIDTH  = 34;
    localparam logic [LIMIT_WIDTH-1:0] INT_LIMIT = 34'd9999999999;
    localparam logic [PLACES_WIDTH-1:0] PLACES_RESET = 3'd2;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_POINT = 8'h2E;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_INT,
        ST_POINT,
        ST_FRAC
    } state_t;

    typedef enum logic [1:0] {
        KIND_MINUS,
        KIND_POINT,
        KIND_INT,
        KIND_FRAC
    } char_kind_t;

    typedef struct packed {
        logic       load;
        logic       dabble;
        logic       skip;
        logic       emit;
        char_kind_t kind;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic neg;
        logic bit_last;
        logic top_zero;
        logic digit_last;
        logic places_zero;
        logic frac_last;
    } status_t;

endpackage

`default_nettype wire

>>> sv/fixed_to_decimal_ascii.sv
// After a word is accepted, the integer magnitude, saturated to 9999999999, goes through
// shift-add-3 over its SW = min(48 - FRACTION_BITS, 34) low bits. Leading zero digits are
// skipped (one always stays); then a minus sign for a negative value, the integer digits and,
// if places is not zero, the point and places fraction digits are emitted, each one waiting
// while the sink holds a word back. No new word is taken before the final one. Reset (aresetn
// low, synchronous) empties the output, idles the controller and sets fraction_digits to 2.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fixed_to_decimal_ascii #(
    parameter int MAX_FRACTION_DIGITS = 4,
    parameter int FRACTION_BITS       = 16
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_we,
    input  wire  [ftda_pkg::PLACES_WIDTH-1:0]   cfg_wdata,  // fraction_digits
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [ftda_pkg::VALUE_WIDTH-1:0]    s_tdata,    // value
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [ftda_pkg::CHAR_WIDTH-1:0]     m_tdata,    // ascii_char
    output logic                                m_tlast
);
    import ftda_pkg::*;

    logic [PLACES_WIDTH-1:0] fraction_digits_reg;
    logic [PLACES_WIDTH-1:0] places;
    cmd_t                    cmd;
    status_t                 status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fraction_digits_reg <= PLACES_RESET;
        end else if (cfg_we) begin
            fraction_digits_reg <= cfg_wdata;
        end
    end

    assign places = (fraction_digits_reg > PLACES_WIDTH'(MAX_FRACTION_DIGITS))
                    ? PLACES_WIDTH'(MAX_FRACTION_DIGITS) : fraction_digits_reg;

    ftda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ftda_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .value    (s_tdata),
        .places   (places),
        .cmd      (cmd),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .status   (status)
    );

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input accepted while converting")
    `ASSERT_IMPLIES(a_last_is_digit, aclk, aresetn, m_tvalid && m_tlast, (m_tdata >= CHAR_ZERO) && (m_tdata <= CHAR_NINE), "final word is not a digit")
    `ASSERT_IMPLIES(a_minus_not_last, aclk, aresetn, m_tvalid && (m_tdata == CHAR_MINUS), !m_tlast, "minus sign marked as final word")

endmodule

`default_nettype wire

>>> sv/ftda_ctrl.sv
// Controller of the decimal text converter: sequences conversion and output.
// Depends on ftda_pkg; drives the datapath by commands and reads its status.
`timescale 1ns / 1ps
`default_nettype none

module ftda_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    input  ftda_pkg::status_t status,
    output ftda_pkg::cmd_t   cmd
);
    import ftda_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = KIND_INT;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.dabble = 1'b1;
                if (status.bit_last) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                priority if (status.top_zero && !status.digit_last) begin
                    cmd.skip = 1'b1;
                end else if (status.neg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_INT;
                end
            end
            ST_SIGN: begin
                cmd.kind = KIND_MINUS;
                if (status.slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_INT;
                end
            end
            ST_INT: begin
                cmd.kind = KIND_INT;
                cmd.last = status.places_zero && status.digit_last;
                if (status.slot_free) begin
                    cmd.emit = 1'b1;
                    if (status.digit_last) begin
                        state_next = status.places_zero ? ST_IDLE : ST_POINT;
                    end
                end
            end
            ST_POINT: begin
                cmd.kind = KIND_POINT;
                if (status.slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC: begin
                cmd.kind = KIND_FRAC;
                cmd.last = status.frac_last;
                if (status.slot_free) begin
                    cmd.emit = 1'b1;
                    if (status.frac_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/ftda_datapath.sv
// Datapath of the decimal text converter: magnitude, BCD shift-add-3 unit,
// fraction digit unit and output word register. Depends on ftda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ftda_datapath #(
    parameter int FRACTION_BITS = 16
) (
    input  wire                                       aclk,
    input  wire                                       aresetn,
    input  wire  [ftda_pkg::VALUE_WIDTH-1:0]          value,
    input  wire  [ftda_pkg::PLACES_WIDTH-1:0]         places,
    input  ftda_pkg::cmd_t                            cmd,
    input  wire                                       m_tready,
    output logic                                      m_tvalid,
    output logic [ftda_pkg::CHAR_WIDTH-1:0]           m_tdata,
    output logic                                      m_tlast,
    output ftda_pkg::status_t                         status
);
    import ftda_pkg::*;

    localparam int IW = VALUE_WIDTH - FRACTION_BITS;
    localparam int CW = (IW > LIMIT_WIDTH) ? IW : LIMIT_WIDTH;
    localparam int SW = (IW < LIMIT_WIDTH) ? IW : LIMIT_WIDTH;
    localparam int BW = $clog2(SW + 1);
    localparam int BCD_WIDTH = 4 * INT_DIGITS;

    logic [VALUE_WIDTH-1:0]      mag;
    logic [CW-1:0]               ipart_ext;
    logic [CW-1:0]               ipart_sat;
    logic [BCD_WIDTH-1:0]        bcd_adj;
    logic [FRACTION_BITS+3:0]    frac_x10;

    logic                        neg_reg;
    logic [SW-1:0]               ibits_reg;
    logic [BW-1:0]               bcnt_reg;
    logic [BCD_WIDTH-1:0]        bcd_reg;
    logic [DCNT_WIDTH-1:0]       dcnt_reg;
    logic [FRACTION_BITS-1:0]    frac_reg;
    logic [PLACES_WIDTH-1:0]     fcnt_reg;
    logic                        out_valid_reg;
    logic [CHAR_WIDTH-1:0]       out_char_reg;
    logic                        out_last_reg;

    assign mag       = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
    assign ipart_ext = CW'(mag[VALUE_WIDTH-1:FRACTION_BITS]);
    assign ipart_sat = (ipart_ext > CW'(INT_LIMIT)) ? CW'(INT_LIMIT) : ipart_ext;
    assign frac_x10  = ({4'b0000, frac_reg} << 3) + ({4'b0000, frac_reg} << 1);

    always_comb begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < INT_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg   <= value[VALUE_WIDTH-1];
            ibits_reg <= ipart_sat[SW-1:0];
            bcnt_reg  <= BW'(SW);
            bcd_reg   <= '0;
            dcnt_reg  <= DCNT_WIDTH'(INT_DIGITS);
            frac_reg  <= mag[FRACTION_BITS-1:0];
            fcnt_reg  <= places;
        end
        if (cmd.dabble) begin
            bcd_reg   <= {bcd_adj[BCD_WIDTH-2:0], ibits_reg[SW-1]};
            ibits_reg <= {ibits_reg[SW-2:0], 1'b0};
            bcnt_reg  <= bcnt_reg - 1'b1;
        end
        if (cmd.skip || (cmd.emit && cmd.kind == KIND_INT)) begin
            bcd_reg  <= {bcd_reg[BCD_WIDTH-5:0], 4'b0000};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.emit && cmd.kind == KIND_FRAC) begin
            frac_reg <= frac_x10[FRACTION_BITS-1:0];
            fcnt_reg <= fcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_last_reg <= cmd.last;
            unique case (cmd.kind)
                KIND_MINUS: out_char_reg <= CHAR_MINUS;
                KIND_POINT: out_char_reg <= CHAR_POINT;
                KIND_INT:   out_char_reg <= CHAR_ZERO + {4'b0000, bcd_reg[BCD_WIDTH-1 -: 4]};
                KIND_FRAC:  out_char_reg <= CHAR_ZERO
                                            + {4'b0000, frac_x10[FRACTION_BITS+3:FRACTION_BITS]};
                default:    out_char_reg <= CHAR_ZERO;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    assign status.slot_free   = !out_valid_reg || m_tready;
    assign status.neg         = neg_reg;
    assign status.bit_last    = (bcnt_reg == BW'(1));
    assign status.top_zero    = (bcd_reg[BCD_WIDTH-1 -: 4] == 4'd0);
    assign status.digit_last  = (dcnt_reg == DCNT_WIDTH'(1));
    assign status.places_zero = (fcnt_reg == '0);
    assign status.frac_last   = (fcnt_reg == PLACES_WIDTH'(1));

endmodule

`default_nettype wire
